FILE: hdl/hdpd_pkg.sv
// Shared types and constants for the Huffman delta-PCM decoder.
// Used by hdpd_ctrl, hdpd_datapath and huffman_delta_pcm_decoder_core.
`timescale 1ns / 1ps

package hdpd_pkg;

   localparam int DICT_WORDS      = 512;
   localparam int DICT_ADDR_WIDTH = $clog2(DICT_WORDS);
   localparam int WORD_WIDTH      = 16;
   localparam int SAMPLE_WIDTH    = 8;
   localparam int BIT_COUNT_WIDTH = 24;
   localparam int BYTE_WIDTH      = 8;
   localparam int BIT_INDEX_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [1:0] OP_DICT_WRITE = 2'd0;
   localparam logic [1:0] OP_DATA       = 2'd1;
   localparam logic [1:0] OP_START      = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DATA_BITS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEUTRAL   = 1'd1;

   localparam logic [SAMPLE_WIDTH-1:0] NEUTRAL_RESET = 8'd128;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [8:0]                   dict_address;
      logic signed [WORD_WIDTH-1:0] dict_word;
      logic [BYTE_WIDTH-1:0]        data_byte;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    last;
      logic                    stream_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic mem_write;
      logic start;
      logic load_byte;
      logic read_next;
      logic take_bit;
      logic leaf_advance;
      logic take_diff;
      logic stage_sample;
      logic stage_done;
      logic flush_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic playing;
      logic at_end;
      logic bits_empty;
      logic word_zero;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/huffman_delta_pcm_decoder_core.sv
// Huffman tree-walk delta-PCM decoder, top level: configuration registers,
// controller and datapath. Depends on hdpd_pkg, hdpd_ctrl, hdpd_datapath.
//
// Usage: load the dictionary with write items (opcode 0), set data_bits and
// neutral_level through the csr_ write port, send a start item (opcode 2),
// then send data bytes (opcode 1). Each byte gives zero to nine samples on
// the rsp_ channel; the final one of a byte carries last. When data_bits
// bits have been used, one neutral_level sample with stream_done follows
// and later bytes give nothing until the next start.
// Dictionary writes, starts and ignored items are taken without a stall. A
// data byte holds req_stall high while the walk steps through its bits. The
// walk is bound by the single dictionary read port, whose read data is
// registered. A result is registered onto rsp_ once the walk finds it is
// not the last of the byte, or as the byte finishes. A stalled receiver
// holds the output register; the walk then waits when its one held result
// cannot move on.
// Reset clears the pointer, accumulator, bit count and playing flag, sets
// data_bits to 0 and neutral_level to 128; the dictionary is not cleared.
`timescale 1ns / 1ps

module huffman_delta_pcm_decoder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  hdpd_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output hdpd_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [hdpd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [hdpd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0] data_bits_ff, data_bits_in;
   logic [hdpd_pkg::SAMPLE_WIDTH-1:0]    neutral_ff, neutral_in;

   hdpd_pkg::cmd_type    cmd;
   hdpd_pkg::status_type status;
   logic                 req_stall_int;

   always_comb begin
      data_bits_in = data_bits_ff;
      neutral_in   = neutral_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hdpd_pkg::CSR_DATA_BITS:
               data_bits_in = csr_write_data[hdpd_pkg::BIT_COUNT_WIDTH-1:0];
            hdpd_pkg::CSR_NEUTRAL:
               neutral_in = csr_write_data[hdpd_pkg::SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= '0;
         neutral_ff   <= hdpd_pkg::NEUTRAL_RESET;
      end else begin
         data_bits_ff <= data_bits_in;
         neutral_ff   <= neutral_in;
      end
   end

   hdpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .req_stall  (req_stall_int),
      .status     (status),
      .cmd        (cmd)
   );

   hdpd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_payload   (req_payload),
      .data_bits     (data_bits_ff),
      .neutral_level (neutral_ff),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload)
   );

   assign req_stall = req_stall_int;

endmodule

FILE: hdl/hdpd_datapath.sv
// Datapath of the decoder: dictionary memory, tree pointer, accumulator,
// bit counters, pending result and output register. Depends on hdpd_pkg.
`timescale 1ns / 1ps

module hdpd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hdpd_pkg::cmd_type                      cmd,
   output hdpd_pkg::status_type                   status,
   input  hdpd_pkg::req_type                      req_payload,
   input  logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0]   data_bits,
   input  logic [hdpd_pkg::SAMPLE_WIDTH-1:0]      neutral_level,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output hdpd_pkg::rsp_type                      rsp_payload
);

   localparam int AW = hdpd_pkg::DICT_ADDR_WIDTH;
   localparam int WW = hdpd_pkg::WORD_WIDTH;
   localparam int SW = hdpd_pkg::SAMPLE_WIDTH;
   localparam logic [WW:0] HALF = (WW+1)'(1 << (SW - 1));
   localparam logic [WW-1:0] TOP = WW'((1 << SW) - 1);

   logic [WW-1:0] mem [hdpd_pkg::DICT_WORDS];
   logic [WW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;

   logic [AW-1:0]                          ptr_ff, ptr_in;
   logic [WW-1:0]                          acc_ff, acc_in;
   logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0]   used_ff, used_in;
   logic                                   playing_ff, playing_in;
   logic [hdpd_pkg::BYTE_WIDTH-1:0]        shift_ff, shift_in;
   logic [hdpd_pkg::BIT_INDEX_WIDTH-1:0]   bitcnt_ff, bitcnt_in;
   logic                                   pend_valid_ff, pend_valid_in;
   logic [SW-1:0]                          pend_sample_ff, pend_sample_in;
   logic                                   pend_done_ff, pend_done_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   hdpd_pkg::rsp_type                      rsp_ff, rsp_in;

   logic [AW-1:0] skip;
   logic [WW:0]   biased;
   logic [SW-1:0] clamped;
   logic          out_free;
   logic          push;

   assign rd_addr = cmd.read_next ? ptr_ff + AW'(1) : ptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[req_payload.dict_address[AW-1:0]] <= req_payload.dict_word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // pointer skip on a one bit: word plus one, or two on a zero word
   assign skip = (rd_data_ff == '0) ? AW'(2) : rd_data_ff[AW-1:0] + AW'(1);

   assign biased  = {acc_ff[WW-1], acc_ff} + HALF;
   assign clamped = biased[WW] ? '0 :
                    (biased[WW-1:0] > TOP) ? TOP[SW-1:0] : biased[SW-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push     = (cmd.stage_sample || cmd.stage_done || cmd.flush_last) && pend_valid_ff;

   always_comb begin
      ptr_in         = ptr_ff;
      acc_in         = acc_ff;
      used_in        = used_ff;
      playing_in     = playing_ff;
      shift_in       = shift_ff;
      bitcnt_in      = bitcnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_sample_in = pend_sample_ff;
      pend_done_in   = pend_done_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;

      if (cmd.start) begin
         ptr_in     = '0;
         acc_in     = '0;
         used_in    = '0;
         playing_in = 1'b1;
      end
      if (cmd.load_byte) begin
         shift_in  = req_payload.data_byte;
         bitcnt_in = hdpd_pkg::BIT_INDEX_WIDTH'(hdpd_pkg::BYTE_WIDTH);
      end
      if (cmd.take_bit) begin
         if (shift_ff[hdpd_pkg::BYTE_WIDTH-1]) begin
            ptr_in = ptr_ff + skip;
         end
         shift_in  = shift_ff << 1;
         bitcnt_in = bitcnt_ff - 1'b1;
         used_in   = used_ff + 1'b1;
      end
      if (cmd.leaf_advance) begin
         ptr_in = ptr_ff + AW'(1);
      end
      if (cmd.take_diff) begin
         acc_in = acc_ff + rd_data_ff;
         ptr_in = '0;
      end
      // hand the held result to the output, then hold the new one
      if (push) begin
         rsp_valid_in       = 1'b1;
         rsp_in.sample      = pend_sample_ff;
         rsp_in.last        = cmd.flush_last;
         rsp_in.stream_done = pend_done_ff;
      end
      if (cmd.stage_sample) begin
         pend_valid_in  = 1'b1;
         pend_sample_in = clamped;
         pend_done_in   = 1'b0;
      end
      if (cmd.stage_done) begin
         pend_valid_in  = 1'b1;
         pend_sample_in = neutral_level;
         pend_done_in   = 1'b1;
         playing_in     = 1'b0;
      end
      if (cmd.flush_last) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         acc_ff        <= '0;
         used_ff       <= '0;
         playing_ff    <= 1'b0;
         bitcnt_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         acc_ff        <= acc_in;
         used_ff       <= used_in;
         playing_ff    <= playing_in;
         bitcnt_ff     <= bitcnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      shift_ff       <= shift_in;
      pend_sample_ff <= pend_sample_in;
      pend_done_ff   <= pend_done_in;
      rsp_ff         <= rsp_in;
   end

   assign status.playing    = playing_ff;
   assign status.at_end     = (used_ff >= data_bits);
   assign status.bits_empty = (bitcnt_ff == '0);
   assign status.word_zero  = (rd_data_ff == '0);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/hdpd_ctrl.sv
// Controller state machine: sequences the bit-by-bit tree walk of one
// data byte through the datapath. Depends on hdpd_pkg.
`timescale 1ns / 1ps

module hdpd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_opcode,
   output logic                  req_stall,
   input  hdpd_pkg::status_type  status,
   output hdpd_pkg::cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CHECK   = 4'd1;
   localparam logic [3:0] ST_STEP    = 4'd2;
   localparam logic [3:0] ST_LEAF_RD = 4'd3;
   localparam logic [3:0] ST_LEAF    = 4'd4;
   localparam logic [3:0] ST_DIFF    = 4'd5;
   localparam logic [3:0] ST_SAMPLE  = 4'd6;
   localparam logic [3:0] ST_DONE    = 4'd7;
   localparam logic [3:0] ST_FLUSH   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       can_stage;

   // staging is blocked only while a held result cannot leave
   assign can_stage = !status.pend_valid || status.out_free;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  hdpd_pkg::OP_DICT_WRITE: cmd.mem_write = 1'b1;
                  hdpd_pkg::OP_START:      cmd.start = 1'b1;
                  hdpd_pkg::OP_DATA: begin
                     if (status.playing) begin
                        cmd.load_byte = 1'b1;
                        state_in      = ST_CHECK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            // memory reads the word at the pointer during this state
            if (status.at_end) begin
               state_in = ST_DONE;
            end else if (status.bits_empty) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.take_bit = 1'b1;
            state_in     = ST_LEAF_RD;
         end
         ST_LEAF_RD: begin
            state_in = ST_LEAF;
         end
         ST_LEAF: begin
            if (status.word_zero) begin
               cmd.read_next = 1'b1;
               state_in      = ST_DIFF;
            end else begin
               cmd.leaf_advance = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         ST_DIFF: begin
            cmd.take_diff = 1'b1;
            state_in      = ST_SAMPLE;
         end
         ST_SAMPLE: begin
            if (can_stage) begin
               cmd.stage_sample = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (can_stage) begin
               cmd.stage_done = 1'b1;
               state_in       = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush_last = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: test/tb_top.sv
// Self-checking bench for huffman_delta_pcm_decoder_core: random items go through
// the valid/stall channels and a tree-walk decoder in the bench predicts every sample.
// Depends on hdpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 220;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SAMPLE_HALF   = 1 << (hdpd_pkg::SAMPLE_WIDTH - 1);
   localparam int SAMPLE_TOP    = (1 << hdpd_pkg::SAMPLE_WIDTH) - 1;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   hdpd_pkg::req_type                    req_payload = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   hdpd_pkg::rsp_type                    rsp_payload;
   logic                                 csr_write_enable = 1'b0;
   logic [hdpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [hdpd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   huffman_delta_pcm_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // decoder state as the bench sees it
   logic [hdpd_pkg::WORD_WIDTH-1:0]      dict_mem [0:hdpd_pkg::DICT_WORDS-1];
   logic [hdpd_pkg::DICT_ADDR_WIDTH-1:0] walk_ptr = '0;
   logic [hdpd_pkg::WORD_WIDTH-1:0]      pcm_acc = '0;
   logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0] bit_count = '0;
   logic                                 play_on = 1'b0;
   logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0] stream_bits = '0;
   logic [hdpd_pkg::SAMPLE_WIDTH-1:0]    idle_level = hdpd_pkg::NEUTRAL_RESET;

   hdpd_pkg::req_type pending_reqs[$];
   hdpd_pkg::rsp_type samples_due[$];
   int                req_idle_pct = 31;
   int                rsp_idle_pct = 68;
   int                random_items = 0;
   int                error_count = 0;
   int                cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // walk one item through the tree and queue the samples it produces
   task automatic walk_item(input hdpd_pkg::req_type it);
      int                                   k;
      int                                   n;
      int                                   level;
      logic [hdpd_pkg::WORD_WIDTH-1:0]      w;
      logic [hdpd_pkg::DICT_ADDR_WIDTH-1:0] nxt;
      hdpd_pkg::rsp_type                    r;
      n = 0;
      case (it.opcode)
         hdpd_pkg::OP_DICT_WRITE: dict_mem[it.dict_address] = it.dict_word;
         hdpd_pkg::OP_START: begin
            pcm_acc = '0;
            bit_count = '0;
            walk_ptr = '0;
            play_on = 1'b1;
         end
         hdpd_pkg::OP_DATA: begin
            if (play_on) begin
               for (k = hdpd_pkg::BYTE_WIDTH - 1; k >= -1; k--) begin
                  if (bit_count >= stream_bits) begin
                     r.sample = idle_level;
                     r.last = 1'b0;
                     r.stream_done = 1'b1;
                     samples_due.push_back(r);
                     n++;
                     play_on = 1'b0;
                     break;
                  end
                  if (k < 0) break;
                  if (it.data_byte[k]) begin
                     w = dict_mem[walk_ptr];
                     // offsets wrap modulo the table size in both directions
                     walk_ptr = walk_ptr +
                        ((w != '0) ? (w[hdpd_pkg::DICT_ADDR_WIDTH-1:0] + 1'b1)
                                   : hdpd_pkg::DICT_ADDR_WIDTH'(2));
                  end
                  bit_count = bit_count + 1'b1;
                  if (dict_mem[walk_ptr] == '0) begin
                     nxt = walk_ptr + 1'b1;
                     pcm_acc = pcm_acc + dict_mem[nxt];
                     level = int'($signed(pcm_acc)) + SAMPLE_HALF;
                     if (level < 0) level = 0;
                     else if (level > SAMPLE_TOP) level = SAMPLE_TOP;
                     r.sample = level[hdpd_pkg::SAMPLE_WIDTH-1:0];
                     r.last = 1'b0;
                     r.stream_done = 1'b0;
                     samples_due.push_back(r);
                     n++;
                     walk_ptr = '0;
                  end else begin
                     walk_ptr = walk_ptr + 1'b1;
                  end
               end
               if (n > 0) samples_due[samples_due.size() - 1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // driver: present queued items, stall results at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check result transfers, then predict from the input transfer
   always @(posedge clock) begin : watch_channels
      hdpd_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               report_mismatch($sformatf("sample %0d last %0b done %0b with nothing pending",
                  rsp_payload.sample, rsp_payload.last, rsp_payload.stream_done));
            end else begin
               want = samples_due.pop_front();
               if (rsp_payload.sample !== want.sample || rsp_payload.last !== want.last ||
                   rsp_payload.stream_done !== want.stream_done)
                  report_mismatch($sformatf("got sample %0d last %0b done %0b, want %0d %0b %0b",
                     rsp_payload.sample, rsp_payload.last, rsp_payload.stream_done,
                     want.sample, want.last, want.stream_done));
            end
         end
         if (req_valid && !req_stall) walk_item(req_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("huffman_delta_pcm_decoder_core verification failed");
         $finish;
      end
   end

   // fields that the opcode does not use carry random values
   function automatic hdpd_pkg::req_type noise_req(input logic [1:0] op);
      logic [63:0]       raw;
      hdpd_pkg::req_type r;
      raw = {$urandom, $urandom};
      r = raw[$bits(hdpd_pkg::req_type)-1:0];
      r.opcode = op;
      return r;
   endfunction

   // mostly leaves and short hops, some full-range words
   function automatic logic [hdpd_pkg::WORD_WIDTH-1:0] tree_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return '0;
      if (pick < 75) begin
         return hdpd_pkg::WORD_WIDTH'($urandom_range(0, 16)) - hdpd_pkg::WORD_WIDTH'(8);
      end
      return hdpd_pkg::WORD_WIDTH'($urandom);
   endfunction

   task automatic send_write(input logic [8:0] addr,
                             input logic [hdpd_pkg::WORD_WIDTH-1:0] word);
      hdpd_pkg::req_type r;
      r = noise_req(hdpd_pkg::OP_DICT_WRITE);
      r.dict_address = addr;
      r.dict_word = word;
      pending_reqs.push_back(r);
      random_items++;
   endtask

   task automatic send_data(input logic [hdpd_pkg::BYTE_WIDTH-1:0] value);
      hdpd_pkg::req_type r;
      r = noise_req(hdpd_pkg::OP_DATA);
      r.data_byte = value;
      pending_reqs.push_back(r);
      random_items++;
   endtask

   task automatic send_start();
      pending_reqs.push_back(noise_req(hdpd_pkg::OP_START));
      random_items++;
   endtask

   task automatic send_unused();
      pending_reqs.push_back(noise_req(OP_UNUSED));
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || samples_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [hdpd_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [hdpd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == hdpd_pkg::CSR_DATA_BITS) stream_bits = value[hdpd_pkg::BIT_COUNT_WIDTH-1:0];
      else idle_level = value[hdpd_pkg::SAMPLE_WIDTH-1:0];
   endtask

   initial begin : run_sequence
      int                                   a;
      int                                   n;
      int                                   roll;
      logic [hdpd_pkg::BIT_COUNT_WIDTH-1:0] bits;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // load every entry before any walk; root and entry 2 are leaves so every bit
      // ends a code, with the largest differences of both signs
      send_write(9'd0, '0);
      send_write(9'd1, 16'h7FFF);
      send_write(9'd2, '0);
      send_write(9'd3, 16'h8000);
      for (a = 4; a < hdpd_pkg::DICT_WORDS; a++) send_write(9'(a), tree_word());

      // data while idle and the unused opcode are dropped
      send_data(8'hFF);
      send_unused();
      wait_drained();
      write_csr(hdpd_pkg::CSR_DATA_BITS, '0);
      @(negedge clock);
      // zero length stream: the first byte gives only the done sample
      send_start();
      send_data(8'h3C);
      send_data(8'h3C);
      wait_drained();
      write_csr(hdpd_pkg::CSR_DATA_BITS, 24'd20);
      write_csr(hdpd_pkg::CSR_NEUTRAL, 24'd0);
      @(negedge clock);
      // clamp at both ends, accumulator wrap, end in the middle of a byte
      send_start();
      send_data(8'hFF);
      send_data(8'h00);
      send_data(8'hA5);
      send_data(8'h5A);
      wait_drained();
      write_csr(hdpd_pkg::CSR_DATA_BITS, 24'd8);
      @(negedge clock);
      // eight samples plus done from one byte
      send_start();
      send_data(8'h5A);
      wait_drained();
      write_csr(hdpd_pkg::CSR_DATA_BITS, 24'hFFFFFF);
      write_csr(hdpd_pkg::CSR_NEUTRAL, 24'd255);
      @(negedge clock);
      send_start();
      send_data(8'h81);
      send_start();
      send_data(8'h7E);
      // negative root offset wraps the pointer backward, a full-size one wraps forward
      send_write(9'd0, 16'hFFFD);
      send_data(8'hFF);
      send_data(8'h00);
      send_write(9'd511, '0);
      send_data(8'hC3);
      send_write(9'd0, 16'h01FF);
      send_data(8'hF0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_drained();
         if (random_items < RANDOM_ITEMS / 3) begin
            req_idle_pct = 31;
            rsp_idle_pct = 68;
         end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 68;
            rsp_idle_pct = 31;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 15) bits = hdpd_pkg::BIT_COUNT_WIDTH'($urandom_range(0, 7));
         else if (roll < 60) bits = hdpd_pkg::BIT_COUNT_WIDTH'($urandom_range(8, 96));
         else if (roll < 75) bits = '1;
         else bits = hdpd_pkg::BIT_COUNT_WIDTH'($urandom);
         write_csr(hdpd_pkg::CSR_DATA_BITS, bits);
         write_csr(hdpd_pkg::CSR_NEUTRAL, hdpd_pkg::CSR_DATA_WIDTH'($urandom));
         @(negedge clock);
         repeat ($urandom_range(0, 2)) send_write(9'($urandom), tree_word());
         send_start();
         n = $urandom_range(3, 12);
         repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) send_unused();
            else if (roll < 14) send_write(9'($urandom), tree_word());
            else if (roll < 18) send_start();
            else send_data(hdpd_pkg::BYTE_WIDTH'($urandom));
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("huffman_delta_pcm_decoder_core verification clean");
      end else begin
         $display("huffman_delta_pcm_decoder_core verification failed");
      end
      $finish;
   end

endmodule
